// File: design/lrc_pkg.sv
// Shared types and constants for the Linkwitz-Riley crossover filter.
package lrc_pkg;

    // State and intermediate values are signed Q16.24.
    localparam int DW = 40;
    // Coefficient operand width: Q8.24 plus the carry of sqrt2 + g.
    localparam int CW = 33;
    // Fraction bits of the coefficients and of the state.
    localparam int FB = 24;
    localparam int NUM_CHANNELS_DEF = 8;

    localparam logic [CW-1:0] SQRT2_Q24 = 33'd23726566;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_G    = 2'd1;
    localparam logic [1:0] CFG_H    = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOW   = 2'd0,
        MODE_HIGH  = 2'd1,
        MODE_ALL   = 2'd2,
        MODE_SPLIT = 2'd3
    } t_mode;

    // Operand and destination selects of the datapath register file.
    // RF_SA and RF_SB map to the section given by the command.
    typedef enum logic [3:0] {
        RF_ZERO,
        RF_X,
        RF_SA,
        RF_SB,
        RF_K,
        RF_YH,
        RF_YB,
        RF_YL,
        RF_AP,
        RF_T,
        RF_S2IN
    } t_rsel;

    typedef enum logic [1:0] {
        CF_RG,
        CF_G,
        CF_H,
        CF_SQ2
    } t_coef;

    typedef struct packed {
        logic  load_in;
        logic  mem_rd;
        logic  mem_load;
        logic  mem_wr;
        logic  out_load;
        logic  sect;
        logic  mul_start;
        t_rsel mul_src;
        t_coef mul_coef;
        t_rsel mul_dst;
        logic  alu_en;
        t_rsel alu_a;
        t_rsel alu_b;
        t_rsel alu_c;
        logic  alu_neg_b;
        logic  alu_neg_c;
        t_rsel alu_dst;
    } t_cmd;

    typedef struct packed {
        logic  ch_ok;
        logic  mul_done;
        logic  out_full;
        t_mode mode;
    } t_status;

endpackage

// File: design/lrc_cmul.sv
// Multi-cycle multiply of a signed Q16.24 value by an unsigned Q9.24 coefficient.
module lrc_cmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [lrc_pkg::DW-1:0] i_a,
    input  logic [lrc_pkg::CW-1:0]    i_c,
    output logic                      o_done,
    output logic signed [lrc_pkg::DW-1:0] o_res
);
    import lrc_pkg::*;

    localparam int HW = DW / 2;
    localparam int PW = HW + CW;
    localparam int SW = DW + CW + 1;
    localparam logic [SW-1:0] RND = SW'(1) << (FB - 1);

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_FIN
    } t_mphase;

    t_mphase r_phase;
    logic              r_neg;
    logic [DW-1:0]     r_mag;
    logic [CW-1:0]     r_c;
    logic [PW-1:0]     r_prod;
    logic [PW-1:0]     r_acc;
    logic [SW-1:0]     sum;
    logic [SW-FB-1:0]  mag_r;
    logic              over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_IDLE;
        end else begin
            case (r_phase)
                MP_IDLE: if (i_start) r_phase <= MP_LO;
                MP_LO:   r_phase <= MP_HI;
                MP_HI:   r_phase <= MP_FIN;
                MP_FIN:  r_phase <= MP_IDLE;
                default: r_phase <= MP_IDLE;
            endcase
        end
    end

    // The magnitude is multiplied in two halves, low half first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[DW-1];
            r_mag <= i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
            r_c   <= i_c;
        end
        if (r_phase == MP_LO) begin
            r_prod <= r_mag[HW-1:0] * r_c;
        end
        if (r_phase == MP_HI) begin
            r_acc  <= r_prod;
            r_prod <= r_mag[DW-1:HW] * r_c;
        end
    end

    // Round to nearest on the magnitude, ties away from zero, then saturate.
    always_comb begin
        sum   = {{(SW-PW){1'b0}}, r_acc} + {1'b0, r_prod, {HW{1'b0}}} + RND;
        mag_r = sum[SW-1:FB];
        over  = |mag_r[SW-FB-1:DW-1];
        if (over) begin
            o_res = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            o_res = r_neg ? -$signed(mag_r[DW-1:0]) : $signed(mag_r[DW-1:0]);
        end
    end

    assign o_done = (r_phase == MP_FIN);

endmodule

// File: design/lrc_datapath.sv
// Datapath: configuration registers, state memory, register file, multiplier, adder and output register.
module lrc_datapath #(
    parameter int NUM_CHANNELS = lrc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [2:0]           i_channel,
    input  logic signed [23:0]   i_sample_in,
    input  lrc_pkg::t_cmd        i_cmd,
    output lrc_pkg::t_status     o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_channel_out,
    output logic signed [23:0]   o_out_main,
    output logic signed [23:0]   o_out_high
);
    import lrc_pkg::*;

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [31:0] NCH = NUM_CHANNELS;
    localparam logic signed [DW-1:0] S40_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S40_MIN = {1'b1, {(DW-1){1'b0}}};

    t_mode             r_mode;
    logic [31:0]       r_coef_g;
    logic [24:0]       r_coef_h;

    logic [2:0]        r_ch;
    logic signed [DW-1:0] r_x, r_s1a, r_s1b, r_s2a, r_s2b;
    logic signed [DW-1:0] r_k, r_yh, r_yb, r_yl, r_ap, r_t;
    t_rsel             r_mul_dst;

    logic [4*DW-1:0]   r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    logic [4*DW-1:0]   r_rd;
    logic              r_rd_vld;

    logic              r_out_valid;
    logic [2:0]        r_out_ch;
    logic signed [23:0] r_out_main, r_out_high;

    logic [CH_AW-1:0]  addr;
    logic              ch_ok;
    logic [CW-1:0]     rg;
    logic [CW-1:0]     coef;
    logic signed [DW-1:0] mul_a, mul_res;
    logic              mul_done;
    logic signed [DW-1:0] alu_a, alu_b, alu_c;
    logic signed [DW+1:0] alu_sum;
    logic signed [DW-1:0] alu_res;
    logic              wr_en;
    t_rsel             wr_dst;
    logic signed [DW-1:0] wr_data;
    logic signed [23:0] main_val, high_val;

    function automatic logic signed [DW-1:0] f_rd(input t_rsel sel);
        logic signed [DW-1:0] v;
        case (sel)
            RF_X:    v = r_x;
            RF_SA:   v = i_cmd.sect ? r_s2a : r_s1a;
            RF_SB:   v = i_cmd.sect ? r_s2b : r_s1b;
            RF_K:    v = r_k;
            RF_YH:   v = r_yh;
            RF_YB:   v = r_yb;
            RF_YL:   v = r_yl;
            RF_AP:   v = r_ap;
            RF_T:    v = r_t;
            RF_S2IN: v = (r_mode == MODE_HIGH) ? r_yh : r_yl;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DW-1:0] f_sat40(input logic signed [DW+1:0] v);
        logic signed [DW-1:0] r;
        if (v[DW+1:DW-1] == 3'b000 || v[DW+1:DW-1] == 3'b111) begin
            r = v[DW-1:0];
        end else begin
            r = v[DW+1] ? S40_MIN : S40_MAX;
        end
        return r;
    endfunction

    // Q16.24 to Q1.23: add half an LSB, floor, saturate to 24 bits.
    function automatic logic signed [23:0] f_to_out(input logic signed [DW-1:0] v);
        logic signed [DW:0]   w;
        logic signed [DW-1:0] q;
        logic signed [23:0]   r;
        w = {v[DW-1], v} + (DW+1)'(1);
        q = w[DW:1];
        if ((&q[DW-1:23]) || !(|q[DW-1:23])) begin
            r = q[23:0];
        end else begin
            r = q[DW-1] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LOW;
            r_coef_g <= '0;
            r_coef_h <= 25'h1000000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE: r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_G:    r_coef_g <= i_cfg_data;
                CFG_H:    r_coef_h <= i_cfg_data[24:0];
                default:  ;
            endcase
        end
    end

    assign addr  = CH_AW'(r_ch);
    assign ch_ok = ({29'd0, r_ch} < NCH);
    assign rg    = {1'b0, r_coef_g} + SQRT2_Q24;

    always_comb begin
        case (i_cmd.mul_coef)
            CF_RG:   coef = rg;
            CF_G:    coef = {1'b0, r_coef_g};
            CF_H:    coef = {8'd0, r_coef_h};
            CF_SQ2:  coef = SQRT2_Q24;
            default: coef = '0;
        endcase
    end

    always_comb begin
        mul_a = f_rd(i_cmd.mul_src);
    end

    lrc_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_c     (coef),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Three-term sum, saturated once at the end.
    always_comb begin
        alu_a   = f_rd(i_cmd.alu_a);
        alu_b   = f_rd(i_cmd.alu_b);
        alu_c   = f_rd(i_cmd.alu_c);
        alu_sum = (DW+2)'(alu_a)
                + (i_cmd.alu_neg_b ? -(DW+2)'(alu_b) : (DW+2)'(alu_b))
                + (i_cmd.alu_neg_c ? -(DW+2)'(alu_c) : (DW+2)'(alu_c));
        alu_res = f_sat40(alu_sum);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_dst  = RF_ZERO;
        wr_data = alu_res;
        if (i_cmd.alu_en) begin
            wr_en  = 1'b1;
            wr_dst = i_cmd.alu_dst;
        end else if (mul_done) begin
            wr_en   = 1'b1;
            wr_dst  = r_mul_dst;
            wr_data = mul_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mul_dst <= i_cmd.mul_dst;
        end
        if (i_cmd.load_in) begin
            r_ch <= i_channel;
            r_x  <= {{(DW-25){i_sample_in[23]}}, i_sample_in, 1'b0};
        end
        if (i_cmd.mem_load) begin
            r_s1a <= r_rd_vld ? r_rd[4*DW-1:3*DW] : '0;
            r_s1b <= r_rd_vld ? r_rd[3*DW-1:2*DW] : '0;
            r_s2a <= r_rd_vld ? r_rd[2*DW-1:DW]   : '0;
            r_s2b <= r_rd_vld ? r_rd[DW-1:0]      : '0;
        end else if (wr_en) begin
            case (wr_dst)
                RF_SA: begin
                    if (i_cmd.sect) r_s2a <= wr_data;
                    else r_s1a <= wr_data;
                end
                RF_SB: begin
                    if (i_cmd.sect) r_s2b <= wr_data;
                    else r_s1b <= wr_data;
                end
                RF_K:    r_k  <= wr_data;
                RF_YH:   r_yh <= wr_data;
                RF_YB:   r_yb <= wr_data;
                RF_YL:   r_yl <= wr_data;
                RF_AP:   r_ap <= wr_data;
                RF_T:    r_t  <= wr_data;
                default: ;
            endcase
        end
    end

    // State memory: one word of four states per channel. A channel never
    // written since reset reads as zero through its valid bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[addr] <= {r_s1a, r_s1b, r_s2a, r_s2b};
        end
        if (i_cmd.mem_rd) begin
            r_rd     <= r_mem[addr];
            r_rd_vld <= r_vld[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.mem_wr) begin
            r_vld[addr] <= 1'b1;
        end
    end

    always_comb begin
        main_val = '0;
        high_val = '0;
        if (ch_ok) begin
            case (r_mode)
                MODE_ALL:  main_val = f_to_out(r_ap);
                MODE_HIGH: main_val = f_to_out(r_yh);
                default:   main_val = f_to_out(r_yl);
            endcase
            if (r_mode == MODE_SPLIT) begin
                high_val = f_to_out(r_k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ch   <= r_ch;
            r_out_main <= main_val;
            r_out_high <= high_val;
        end
    end

    assign o_status.ch_ok    = ch_ok;
    assign o_status.mul_done = mul_done;
    assign o_status.out_full = r_out_valid & ~i_out_ready;
    assign o_status.mode     = r_mode;

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_out_main    = r_out_main;
    assign o_out_high    = r_out_high;

endmodule

// File: design/lrc_ctrl.sv
// Controller: sequences the two filter sections through the shared multiplier and adder.
module lrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lrc_pkg::t_status  i_status,
    output lrc_pkg::t_cmd     o_cmd
);
    import lrc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_M_SA,
        S_A_K,
        S_M_YH,
        S_M_GH,
        S_A_YB,
        S_A_SA,
        S_M_GB,
        S_A_YL,
        S_A_SB,
        S_M_BQ,
        S_A_AP,
        S_A_HI,
        S_OUT
    } t_state;

    t_state r_state, n_state, mul_next;
    logic   r_sect, n_sect;
    logic   r_wait, n_wait;
    logic   is_mul;

    always_comb begin
        n_state    = r_state;
        n_sect     = r_sect;
        n_wait     = r_wait;
        mul_next   = r_state;
        is_mul     = 1'b0;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.sect = r_sect;

        case (r_state)
            S_IDLE: begin
                // No beat is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load_in = 1'b1;
                    n_sect        = 1'b0;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if (i_status.ch_ok) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_LOAD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LOAD: begin
                o_cmd.mem_load = 1'b1;
                n_state        = S_M_SA;
            end
            S_M_SA: begin
                is_mul         = 1'b1;
                o_cmd.mul_src  = RF_SA;
                o_cmd.mul_coef = CF_RG;
                o_cmd.mul_dst  = RF_T;
                mul_next       = S_A_K;
            end
            S_A_K: begin
                o_cmd.alu_en    = 1'b1;
                o_cmd.alu_a     = r_sect ? RF_S2IN : RF_X;
                o_cmd.alu_b     = RF_T;
                o_cmd.alu_neg_b = 1'b1;
                o_cmd.alu_c     = RF_SB;
                o_cmd.alu_neg_c = 1'b1;
                o_cmd.alu_dst   = RF_K;
                n_state         = S_M_YH;
            end
            S_M_YH: begin
                is_mul         = 1'b1;
                o_cmd.mul_src  = RF_K;
                o_cmd.mul_coef = CF_H;
                o_cmd.mul_dst  = RF_YH;
                mul_next       = S_M_GH;
            end
            S_M_GH: begin
                is_mul         = 1'b1;
                o_cmd.mul_src  = RF_YH;
                o_cmd.mul_coef = CF_G;
                o_cmd.mul_dst  = RF_T;
                mul_next       = S_A_YB;
            end
            S_A_YB: begin
                o_cmd.alu_en  = 1'b1;
                o_cmd.alu_a   = RF_T;
                o_cmd.alu_b   = RF_SA;
                o_cmd.alu_c   = RF_ZERO;
                o_cmd.alu_dst = RF_YB;
                n_state       = S_A_SA;
            end
            S_A_SA: begin
                o_cmd.alu_en  = 1'b1;
                o_cmd.alu_a   = RF_T;
                o_cmd.alu_b   = RF_YB;
                o_cmd.alu_c   = RF_ZERO;
                o_cmd.alu_dst = RF_SA;
                n_state       = S_M_GB;
            end
            S_M_GB: begin
                is_mul         = 1'b1;
                o_cmd.mul_src  = RF_YB;
                o_cmd.mul_coef = CF_G;
                o_cmd.mul_dst  = RF_T;
                mul_next       = S_A_YL;
            end
            S_A_YL: begin
                o_cmd.alu_en  = 1'b1;
                o_cmd.alu_a   = RF_T;
                o_cmd.alu_b   = RF_SB;
                o_cmd.alu_c   = RF_ZERO;
                o_cmd.alu_dst = RF_YL;
                n_state       = S_A_SB;
            end
            S_A_SB: begin
                o_cmd.alu_en  = 1'b1;
                o_cmd.alu_a   = RF_T;
                o_cmd.alu_b   = RF_YL;
                o_cmd.alu_c   = RF_ZERO;
                o_cmd.alu_dst = RF_SB;
                if (!r_sect) begin
                    n_state = S_M_BQ;
                end else if (i_status.mode == MODE_SPLIT) begin
                    n_state = S_A_HI;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_M_BQ: begin
                is_mul         = 1'b1;
                o_cmd.mul_src  = RF_YB;
                o_cmd.mul_coef = CF_SQ2;
                o_cmd.mul_dst  = RF_T;
                mul_next       = S_A_AP;
            end
            S_A_AP: begin
                o_cmd.alu_en    = 1'b1;
                o_cmd.alu_a     = RF_YL;
                o_cmd.alu_b     = RF_T;
                o_cmd.alu_neg_b = 1'b1;
                o_cmd.alu_c     = RF_YH;
                o_cmd.alu_dst   = RF_AP;
                if (i_status.mode == MODE_ALL) begin
                    n_state = S_OUT;
                end else begin
                    n_sect  = 1'b1;
                    n_state = S_M_SA;
                end
            end
            S_A_HI: begin
                // High band of the split: first-section allpass minus low band.
                o_cmd.alu_en    = 1'b1;
                o_cmd.alu_a     = RF_AP;
                o_cmd.alu_b     = RF_YL;
                o_cmd.alu_neg_b = 1'b1;
                o_cmd.alu_c     = RF_ZERO;
                o_cmd.alu_dst   = RF_K;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.mem_wr   = i_status.ch_ok;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A product step starts the multiplier once, then waits for its result.
        if (is_mul) begin
            if (!r_wait) begin
                o_cmd.mul_start = 1'b1;
                n_wait          = 1'b1;
            end else if (i_status.mul_done) begin
                n_wait  = 1'b0;
                n_state = mul_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sect  <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sect  <= n_sect;
            r_wait  <= n_wait;
        end
    end

endmodule

// File: design/linkwitz_riley_crossover_filter.sv
// Top level of the per-channel fourth-order Linkwitz-Riley crossover filter.
//
// Each input beat carries a channel and a signed Q1.23 sample and yields one
// output beat. Two cascaded state-variable sections run on a shared 20x33-bit
// multiplier, which works on one product at a time, and a saturating
// three-input adder, driven by a controller. An input beat takes five
// products in allpass mode and nine in lowpass, highpass and split mode; a
// channel at or above NUM_CHANNELS takes none and leaves the state alone.
// The result sits in an output register, so the next input is taken while
// it waits; the block stalls only when a new result is ready and the old one
// is still held. Per-channel states sit in a memory with valid bits, so they
// read as zero after reset with no clearing pass. Configuration writes are
// taken whenever reset is released (cfg ready follows the reset) and must
// only happen while the block is idle.
module linkwitz_riley_crossover_filter #(
    parameter int NUM_CHANNELS = lrc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_channel,
    input  logic signed [23:0]  i_sample_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_channel_out,
    output logic signed [23:0]  o_out_main,
    output logic signed [23:0]  o_out_high
);
    import lrc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = i_rst_n;

    lrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lrc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_channel_out (o_channel_out),
        .o_out_main    (o_out_main),
        .o_out_high    (o_out_high)
    );

endmodule
